// ===== sv/asvs_pkg.sv =====
// ----------------------------------------------------------------------------
// asvs_pkg
// Shared widths, constants and register codes for the adaptive sample
// variance stop block.
// ----------------------------------------------------------------------------
package asvs_pkg;

  // field widths
  localparam int COLOR_W     = 8;
  localparam int MIN_W       = 11;
  localparam int LIMIT_W     = 32;
  localparam int COUNT_OUT_W = 11;
  localparam int MEAN_W      = 24;
  localparam int LUMA16_W    = 16;
  localparam int M2_W        = 44;
  localparam int VAR_W       = 32;
  localparam int PROD_W      = 2 * MEAN_W;
  localparam int PROD_SHIFT  = 16;

  // luma weights in Q0.16, they sum to exactly one
  localparam logic [LUMA16_W-1:0] LUMA_R_COEF = 16'd13933;
  localparam logic [LUMA16_W-1:0] LUMA_G_COEF = 16'd46871;
  localparam logic [LUMA16_W-1:0] LUMA_B_COEF = 16'd4732;

  // default sample limit
  localparam int MAX_SAMPLES_DEF = 1024;

  // divider step counts
  localparam int STEP_W         = $clog2(M2_W + 1);
  localparam int MEAN_DIV_STEPS = MEAN_W;
  localparam int VAR_DIV_STEPS  = M2_W;

  // configuration port
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;
  localparam int REG_IDX_LSB = 2;

  localparam logic [MIN_W-1:0]   MIN_SAMPLES_RST    = 11'd16;
  localparam logic [LIMIT_W-1:0] VARIANCE_LIMIT_RST = 32'd429497;

  // register index codes
  localparam logic REG_MIN_SAMPLES    = 1'b0;
  localparam logic REG_VARIANCE_LIMIT = 1'b1;

endpackage

// ===== sv/adaptive_sample_variance_stop.sv =====
// ----------------------------------------------------------------------------
// adaptive_sample_variance_stop
// Per-pixel Welford running mean and M2 of sample luma, with a variance stop
// test against a programmable limit.
// ----------------------------------------------------------------------------
// Order of work: capture, luma, mean division, mean update, multiply, M2
// accumulation, variance division (skipped when the count is one), finish.
// Both divisions use the shared one-bit-per-cycle restoring divider, 24
// steps for the mean update and 44 steps for the variance. No new item is
// taken until the last one's result is in the output register, where it
// waits while the next item is taken.
// Reset: synchronous; clears statistics, sequencer and output valid, and
// loads the register defaults (min_samples 16, variance_limit 429497).
module adaptive_sample_variance_stop #(
  parameter int MAX_SAMPLES = asvs_pkg::MAX_SAMPLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              new_pixel,
  input  logic [asvs_pkg::COLOR_W-1:0]      red,
  input  logic [asvs_pkg::COLOR_W-1:0]      green,
  input  logic [asvs_pkg::COLOR_W-1:0]      blue,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              keep_sampling,
  output logic [asvs_pkg::COUNT_OUT_W-1:0]  sample_count,
  output logic [asvs_pkg::MEAN_W-1:0]       mean_luma,
  output logic [asvs_pkg::VAR_W-1:0]        sample_variance,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [asvs_pkg::ADDR_W-1:0]       paddr,
  input  logic [asvs_pkg::DATA_W-1:0]       pwdata,
  output logic [asvs_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int CMP_W = (CNT_W > asvs_pkg::MIN_W) ? CNT_W : asvs_pkg::MIN_W;
  localparam int SUM_W = asvs_pkg::MEAN_W;
  localparam int ACC_W = asvs_pkg::M2_W + 1;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_LUMA     = 8'b0000_0010,
    ST_DIV_MEAN = 8'b0000_0100,
    ST_UPDATE   = 8'b0000_1000,
    ST_MULT     = 8'b0001_0000,
    ST_ACC      = 8'b0010_0000,
    ST_DIV_VAR  = 8'b0100_0000,
    ST_FINISH   = 8'b1000_0000
  } state_t;

  state_t state;

  // configuration registers
  logic [asvs_pkg::MIN_W-1:0]   min_samples;
  logic [asvs_pkg::LIMIT_W-1:0] variance_limit;

  // pixel statistics
  logic [CNT_W-1:0]             count;
  logic [asvs_pkg::MEAN_W-1:0]  running_mean;
  logic [asvs_pkg::M2_W-1:0]    squares_sum;

  // captured sample and working values
  logic [asvs_pkg::COLOR_W-1:0] red_q;
  logic [asvs_pkg::COLOR_W-1:0] green_q;
  logic [asvs_pkg::COLOR_W-1:0] blue_q;
  logic [asvs_pkg::MEAN_W-1:0]  luma;
  logic                         neg;
  logic [asvs_pkg::MEAN_W-1:0]  d_mag;
  logic [asvs_pkg::MEAN_W-1:0]  d2_mag;
  logic [asvs_pkg::PROD_W-1:0]  prod;
  logic                         var_zero;

  // shared divider
  logic [CNT_W-1:0]             div_rem;
  logic [asvs_pkg::M2_W-1:0]    div_quo;
  logic [CNT_W-1:0]             div_den;
  logic [asvs_pkg::STEP_W-1:0]  div_cnt;
  logic [CNT_W:0]               div_trial;
  logic [CNT_W:0]               div_diff;
  logic                         div_ge;
  logic [CNT_W-1:0]             div_rem_next;
  logic [asvs_pkg::M2_W-1:0]    div_quo_next;

  // combinational values
  logic                         in_xfer;
  logic                         out_xfer;
  logic                         cfg_write;
  logic                         reg_idx;
  logic [SUM_W-1:0]             luma_sum;
  logic [asvs_pkg::MEAN_W-1:0]  luma_next;
  logic [CNT_W-1:0]             n_next;
  logic                         neg_next;
  logic [asvs_pkg::MEAN_W-1:0]  d_mag_next;
  logic [asvs_pkg::MEAN_W-1:0]  mean_next;
  logic [asvs_pkg::MEAN_W-1:0]  d2_mag_next;
  logic [ACC_W-1:0]             m2_sum;
  logic [asvs_pkg::M2_W-1:0]    m2_next;
  logic [asvs_pkg::VAR_W-1:0]   var_next;
  logic                         keep_next;
  logic                         out_free;

  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign out_free  = !out_valid || !out_stall;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[asvs_pkg::REG_IDX_LSB];

  // register read-back
  always_comb begin
    case (reg_idx)
      asvs_pkg::REG_MIN_SAMPLES:    prdata = asvs_pkg::DATA_W'(min_samples);
      asvs_pkg::REG_VARIANCE_LIMIT: prdata = asvs_pkg::DATA_W'(variance_limit);
      default:                      prdata = '0;
    endcase
  end

  // luma in Q0.16, widened to Q0.24
  always_comb begin
    luma_sum = SUM_W'(red_q) * SUM_W'(asvs_pkg::LUMA_R_COEF)
             + SUM_W'(green_q) * SUM_W'(asvs_pkg::LUMA_G_COEF)
             + SUM_W'(blue_q) * SUM_W'(asvs_pkg::LUMA_B_COEF);
    luma_next = {luma_sum[SUM_W-1 -: asvs_pkg::LUMA16_W],
                 {(asvs_pkg::MEAN_W - asvs_pkg::LUMA16_W){1'b0}}};
  end

  // saturating sample count and first deviation
  always_comb begin
    n_next     = (count == CNT_W'(MAX_SAMPLES)) ? count : count + 1'b1;
    neg_next   = luma_next < running_mean;
    d_mag_next = neg_next ? running_mean - luma_next : luma_next - running_mean;
  end

  // one restoring division step
  always_comb begin
    div_trial    = {div_rem, div_quo[asvs_pkg::M2_W-1]};
    div_diff     = div_trial - {1'b0, div_den};
    div_ge       = (div_trial >= {1'b0, div_den});
    div_rem_next = div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
    div_quo_next = {div_quo[asvs_pkg::M2_W-2:0], div_ge};
  end

  // mean update and second deviation
  always_comb begin
    mean_next   = neg ? running_mean - div_quo[asvs_pkg::MEAN_W-1:0]
                      : running_mean + div_quo[asvs_pkg::MEAN_W-1:0];
    d2_mag_next = (luma >= mean_next) ? luma - mean_next : mean_next - luma;
  end

  // saturating M2 accumulation
  always_comb begin
    m2_sum  = {1'b0, squares_sum}
            + ACC_W'(prod[asvs_pkg::PROD_W-1:asvs_pkg::PROD_SHIFT]);
    m2_next = m2_sum[ACC_W-1] ? '1 : m2_sum[asvs_pkg::M2_W-1:0];
  end

  // variance saturation and stop test
  always_comb begin
    if (var_zero) begin
      var_next = '0;
    end else if (|div_quo[asvs_pkg::M2_W-1:asvs_pkg::VAR_W]) begin
      var_next = '1;
    end else begin
      var_next = div_quo[asvs_pkg::VAR_W-1:0];
    end
    keep_next = !((CMP_W'(count) >= CMP_W'(min_samples)) && (var_next <= variance_limit));
  end

  // sequencer, statistics, configuration and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      min_samples    <= asvs_pkg::MIN_SAMPLES_RST;
      variance_limit <= asvs_pkg::VARIANCE_LIMIT_RST;
      count          <= '0;
      running_mean   <= '0;
      squares_sum    <= '0;
      div_cnt        <= '0;
    end else begin
      if (cfg_write) begin
        case (reg_idx)
          asvs_pkg::REG_MIN_SAMPLES:    min_samples <= pwdata[asvs_pkg::MIN_W-1:0];
          asvs_pkg::REG_VARIANCE_LIMIT: variance_limit <= pwdata[asvs_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end

      // a fresh result replaces one leaving in the same cycle
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (new_pixel) begin
              count        <= '0;
              running_mean <= '0;
              squares_sum  <= '0;
            end
            state <= ST_LUMA;
          end
        end
        ST_LUMA: begin
          count   <= n_next;
          div_cnt <= asvs_pkg::STEP_W'(asvs_pkg::MEAN_DIV_STEPS);
          state   <= ST_DIV_MEAN;
        end
        ST_DIV_MEAN: begin
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == asvs_pkg::STEP_W'(1)) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          running_mean <= mean_next;
          state        <= ST_MULT;
        end
        ST_MULT: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          squares_sum <= m2_next;
          div_cnt     <= asvs_pkg::STEP_W'(asvs_pkg::VAR_DIV_STEPS);
          if (count == CNT_W'(1)) begin
            state <= ST_FINISH;
          end else begin
            state <= ST_DIV_VAR;
          end
        end
        ST_DIV_VAR: begin
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == asvs_pkg::STEP_W'(1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          red_q   <= red;
          green_q <= green;
          blue_q  <= blue;
        end
      end
      ST_LUMA: begin
        luma    <= luma_next;
        neg     <= neg_next;
        d_mag   <= d_mag_next;
        div_rem <= '0;
        div_den <= n_next;
        div_quo <= asvs_pkg::M2_W'(d_mag_next) << (asvs_pkg::M2_W - asvs_pkg::MEAN_W);
      end
      ST_DIV_MEAN, ST_DIV_VAR: begin
        div_rem <= div_rem_next;
        div_quo <= div_quo_next;
      end
      ST_UPDATE: begin
        d2_mag <= d2_mag_next;
      end
      ST_MULT: begin
        prod <= asvs_pkg::PROD_W'(d_mag) * asvs_pkg::PROD_W'(d2_mag);
      end
      ST_ACC: begin
        var_zero <= (count == CNT_W'(1));
        div_rem  <= '0;
        div_den  <= count - 1'b1;
        div_quo  <= m2_next;
      end
      ST_FINISH: begin
        if (out_free) begin
          keep_sampling   <= keep_next;
          sample_count    <= asvs_pkg::COUNT_OUT_W'(count);
          mean_luma       <= running_mean;
          sample_variance <= var_next;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the adaptive sample variance stop block. A local
// fixed-point Welford predictor tracks count, mean and M2 per pixel and
// forecasts every result; the output channel is compared field by field.
// Directed cases cover colour extremes, the register extremes and count
// saturation, then random pixels run under several idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;
  import asvs_pkg::*;

  localparam int MAX_SAMPLES  = MAX_SAMPLES_DEF;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_ITEMS  = 190;
  localparam logic [M2_W-1:0] M2_FULL = '1;

  typedef struct packed {
    logic                   keep;
    logic [COUNT_OUT_W-1:0] count;
    logic [MEAN_W-1:0]      mean;
    logic [VAR_W-1:0]       variance;
  } pixel_verdict_t;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic                   new_pixel = 1'b0;
  logic [COLOR_W-1:0]     red       = '0;
  logic [COLOR_W-1:0]     green     = '0;
  logic [COLOR_W-1:0]     blue      = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   keep_sampling;
  logic [COUNT_OUT_W-1:0] sample_count;
  logic [MEAN_W-1:0]      mean_luma;
  logic [VAR_W-1:0]       sample_variance;
  logic                   psel      = 1'b0;
  logic                   penable   = 1'b0;
  logic                   pwrite    = 1'b0;
  logic [ADDR_W-1:0]      paddr     = '0;
  logic [DATA_W-1:0]      pwdata    = '0;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  adaptive_sample_variance_stop #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .new_pixel(new_pixel), .red(red), .green(green), .blue(blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .keep_sampling(keep_sampling), .sample_count(sample_count),
    .mean_luma(mean_luma), .sample_variance(sample_variance),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow registers and per-pixel statistics
  logic [MIN_W-1:0]   min_samples_shadow;
  logic [LIMIT_W-1:0] limit_shadow;
  int unsigned        stat_count;
  logic [MEAN_W-1:0]  stat_mean;
  logic [M2_W-1:0]    stat_m2;

  pixel_verdict_t pending_verdicts[$];
  int          errors         = 0;
  int          sender_idle    = 0;
  int          receiver_stall = 0;
  int          next_gap       = 0;
  int          stall_left     = 0;
  bit          valid_held     = 1'b0;
  int unsigned cycles         = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // fold one sample into the statistics and forecast its result
  function automatic pixel_verdict_t fold_sample(input logic np,
                                                 input logic [COLOR_W-1:0] r, g, b);
    logic [31:0]       weighted;
    logic [MEAN_W-1:0] luma, dev, dist_after, share;
    logic              below;
    int unsigned       n;
    logic [63:0]       m2_next, quotient;
    pixel_verdict_t    v;
    if (np) begin
      stat_count = 0;
      stat_mean  = '0;
      stat_m2    = '0;
    end
    weighted = 32'(r) * 32'(LUMA_R_COEF) + 32'(g) * 32'(LUMA_G_COEF)
             + 32'(b) * 32'(LUMA_B_COEF);
    luma = {weighted[23:8], 8'h00};
    n = (stat_count + 1 > MAX_SAMPLES) ? MAX_SAMPLES : stat_count + 1;
    stat_count = n;
    // mean moves by the truncated share of the deviation
    below = luma < stat_mean;
    dev   = below ? stat_mean - luma : luma - stat_mean;
    share = MEAN_W'(dev / n);
    stat_mean  = below ? stat_mean - share : stat_mean + share;
    dist_after = (luma >= stat_mean) ? luma - stat_mean : stat_mean - luma;
    // saturating M2 accumulation
    m2_next = 64'(stat_m2) + ((64'(dev) * 64'(dist_after)) >> PROD_SHIFT);
    stat_m2 = (m2_next > 64'(M2_FULL)) ? M2_FULL : m2_next[M2_W-1:0];
    quotient   = (n <= 1) ? 64'd0 : 64'(stat_m2) / 64'(n - 1);
    v.variance = (quotient > 64'hFFFF_FFFF) ? '1 : quotient[VAR_W-1:0];
    v.count    = COUNT_OUT_W'(n);
    v.mean     = stat_mean;
    v.keep     = !(n >= min_samples_shadow && v.variance <= limit_shadow);
    return v;
  endfunction

  // colour channel near a base value, clamped to the channel range
  function automatic logic [COLOR_W-1:0] jitter(input logic [COLOR_W-1:0] base,
                                                input int spread);
    int v;
    v = int'(base) + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return COLOR_W'(v);
  endfunction

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    $display("%0t %s: got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  // one input transfer; valid stays high when the next item follows at once
  task automatic send_sample(input logic np, input logic [COLOR_W-1:0] r, g, b);
    repeat (next_gap) @(posedge clk);
    in_valid  <= 1'b1;
    new_pixel <= np;
    red       <= r;
    green     <= g;
    blue      <= b;
    valid_held = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_verdicts.push_back(fold_sample(np, r, g, b));
    next_gap = ($urandom_range(99) < sender_idle) ? $urandom_range(1, 90) : 0;
    if (next_gap != 0) begin
      in_valid  <= 1'b0;
      valid_held = 1'b0;
    end
  endtask

  // drop valid and wait until every forecast result has come back
  task automatic wait_idle();
    if (valid_held) begin
      in_valid  <= 1'b0;
      valid_held = 1'b0;
    end
    next_gap = 0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // register write: setup then access cycle
  task automatic write_register(input logic code, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(code) << REG_IDX_LSB;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (code == REG_MIN_SAMPLES)
      min_samples_shadow = value[MIN_W-1:0];
    else
      limit_shadow = value;
    @(posedge clk);
  endtask

  task automatic configure(input logic [DATA_W-1:0] min_value,
                           input logic [DATA_W-1:0] limit_value);
    wait_idle();
    write_register(REG_MIN_SAMPLES, min_value);
    write_register(REG_VARIANCE_LIMIT, limit_value);
  endtask

  // one pixel: a new-pixel sample then samples scattered around its colour
  task automatic send_pixel(input int samples, input int spread);
    logic [COLOR_W-1:0] br, bg, bb;
    br = COLOR_W'($urandom);
    bg = COLOR_W'($urandom);
    bb = COLOR_W'($urandom);
    for (int i = 0; i < samples; i++)
      send_sample(i == 0, jitter(br, spread), jitter(bg, spread), jitter(bb, spread));
  endtask

  // colour extremes, straight after reset with the default registers
  task automatic test_colour_extremes();
    send_sample(1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_sample(1'b0, 8'h00, 8'h00, 8'h00);
    send_sample(1'b1, 8'h00, 8'h00, 8'h00);
    send_sample(1'b0, 8'hFF, 8'h00, 8'h00);
    send_sample(1'b0, 8'h00, 8'hFF, 8'h00);
    send_sample(1'b0, 8'h00, 8'h00, 8'hFF);
  endtask

  // single samples and a minimum of zero or one with a zero limit
  task automatic test_single_sample();
    configure(1, 0);
    send_sample(1'b1, 8'h80, 8'h40, 8'hC0);
    send_sample(1'b1, 8'hFF, 8'hFF, 8'hFF);
    configure(0, 0);
    send_sample(1'b1, 8'h12, 8'h34, 8'h56);
    send_sample(1'b0, 8'h12, 8'h34, 8'h56);
  endtask

  // minimum beyond the sample ceiling, so the stop test never applies
  task automatic test_minimum_out_of_reach();
    configure(MAX_SAMPLES + 1, 32'hFFFF_FFFF);
    send_sample(1'b1, 8'h55, 8'h55, 8'h55);
    send_sample(1'b0, 8'h55, 8'h55, 8'h55);
    send_sample(1'b0, 8'h55, 8'h55, 8'h55);
    configure(2047, 32'hFFFF_FFFF);
    send_sample(1'b1, 8'hAA, 8'h55, 8'hAA);
    send_sample(1'b0, 8'hAA, 8'h55, 8'hAA);
  endtask

  // variance still reported while the count is below the minimum
  task automatic test_variance_before_minimum();
    configure(MAX_SAMPLES, 32'hFFFF_FFFF);
    send_sample(1'b1, 8'hFF, 8'hFF, 8'hFF);
    send_sample(1'b0, 8'h00, 8'h00, 8'h00);
    send_sample(1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_sample(1'b0, 8'h00, 8'h00, 8'h00);
    send_sample(1'b0, 8'h7F, 8'h7F, 8'h7F);
  endtask

  // one long pixel that runs the count into its ceiling
  task automatic test_count_saturation();
    configure(MAX_SAMPLES, VARIANCE_LIMIT_RST);
    send_pixel(MAX_SAMPLES + 6, 2);
  endtask

  // random pixels under each idle and stall pattern, with fresh settings per half phase
  task automatic test_random_traffic();
    int idle_pct[4]  = '{0, 61, 0, 30};
    int stall_pct[4] = '{0, 0, 61, 30};
    int sent, len;
    logic [DATA_W-1:0] min_value, limit_value;
    for (int phase = 0; phase < 4; phase++) begin
      for (int half = 0; half < 2; half++) begin
        case ($urandom_range(3))
          0:       min_value = 1;
          1:       min_value = $urandom_range(2, 40);
          2:       min_value = $urandom_range(1, 12);
          default: min_value = $urandom_range(0, 2047);
        endcase
        case ($urandom_range(5))
          0:       limit_value = 0;
          1:       limit_value = 32'hFFFF_FFFF;
          2:       limit_value = VARIANCE_LIMIT_RST;
          3:       limit_value = $urandom;
          default: limit_value = $urandom_range(0, 4_000_000);
        endcase
        configure(min_value, limit_value);
        sender_idle    = idle_pct[phase];
        receiver_stall = stall_pct[phase];
        sent = 0;
        while (sent < PHASE_ITEMS / 2) begin
          if ($urandom_range(99) < 85) begin
            len = $urandom_range(1, 48);
            send_pixel(len, $urandom_range(0, 12));
            sent += len;
          end else begin
            // stray samples with random flags and colours
            send_sample(1'($urandom_range(1)), COLOR_W'($urandom), COLOR_W'($urandom),
                        COLOR_W'($urandom));
            sent++;
          end
        end
      end
    end
    sender_idle    = 0;
    receiver_stall = 0;
  endtask

  // receiver back-pressure, mostly short stalls with some long ones
  always @(posedge clk) begin
    if (stall_left == 0 && $urandom_range(99) < receiver_stall)
      stall_left = ($urandom_range(15) == 0) ? $urandom_range(20, 150)
                                             : $urandom_range(1, 6);
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each result transfer with the oldest forecast
  always @(posedge clk) begin
    pixel_verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result with nothing forecast", sample_count, 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (keep_sampling !== want.keep)
          report_mismatch("keep_sampling", keep_sampling, want.keep);
        if (sample_count !== want.count)
          report_mismatch("sample_count", sample_count, want.count);
        if (mean_luma !== want.mean)
          report_mismatch("mean_luma", mean_luma, want.mean);
        if (sample_variance !== want.variance)
          report_mismatch("sample_variance", sample_variance, want.variance);
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("adaptive_sample_variance_stop: mismatch");
      $finish;
    end
  end

  // test sequence
  initial begin
    min_samples_shadow = MIN_SAMPLES_RST;
    limit_shadow       = VARIANCE_LIMIT_RST;
    stat_count         = 0;
    stat_mean          = '0;
    stat_m2            = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_colour_extremes();
    test_single_sample();
    test_minimum_out_of_reach();
    test_variance_before_minimum();
    test_count_saturation();
    test_random_traffic();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("adaptive_sample_variance_stop: match");
    end else begin
      $display("adaptive_sample_variance_stop: mismatch");
    end
    $finish;
  end

endmodule
